[hw/rtl/hrp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrp_pkg
// Shared types and constants for the hex record parser.
// ----------------------------------------------------------------------------
package hrp_pkg;

    localparam logic [7:0] CHAR_START = 8'h3B;  // ';'

    localparam logic [2:0] KIND_DATA    = 3'd0;
    localparam logic [2:0] KIND_OK      = 3'd1;
    localparam logic [2:0] KIND_BAD_SUM = 3'd2;
    localparam logic [2:0] KIND_END     = 3'd3;
    localparam logic [2:0] KIND_BAD_HEX = 3'd4;
    localparam logic [2:0] KIND_EOF     = 3'd5;

    typedef enum logic [4:0] {
        PH_HUNT  = 5'b00001,
        PH_LEN   = 5'b00010,
        PH_ADDR  = 5'b00100,
        PH_DATA  = 5'b01000,
        PH_CHECK = 5'b10000
    } phase_t;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } hex_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] byte_address;
        logic [7:0]  data_byte;
        logic [15:0] sum_computed;
    } result_t;

    typedef struct packed {
        logic res_valid;
        logic halted;
    } core_status_t;

endpackage

[hw/rtl/hrp_hex_decode.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrp_hex_decode
// Maps one character to its hex digit value; flags non-hex characters.
// ----------------------------------------------------------------------------
module hrp_hex_decode (
    input  logic [7:0]   char_in,
    output hrp_pkg::hex_t hex
);

    always_comb begin
        hex.valid = 1'b1;
        hex.value = 4'd0;
        priority if (char_in >= 8'h30 && char_in <= 8'h39) begin
            hex.value = char_in[3:0];
        end else if ((char_in >= 8'h41 && char_in <= 8'h46) ||
                     (char_in >= 8'h61 && char_in <= 8'h66)) begin
            // 'A'..'F' and 'a'..'f' share the low three bits: 1..6
            hex.value = 4'd9 + {1'b0, char_in[2:0]};
        end else begin
            hex.valid = 1'b0;
        end
    end

endmodule

[hw/rtl/hrp_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrp_core
// Record state machine: pairs hex digits into bytes, tracks fields and the
// running checksum, and produces at most one result per accepted beat.
// ----------------------------------------------------------------------------
module hrp_core (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  beat_accept,
    input  logic [7:0]            char_in,
    input  logic                  end_of_input,
    output hrp_pkg::core_status_t status,
    output hrp_pkg::result_t      res
);

    hrp_pkg::phase_t phase_reg, phase_next;
    logic [3:0]  nibble_high_reg, nibble_high_next;
    logic        nibble_pending_reg, nibble_pending_next;
    logic        field_idx_reg, field_idx_next;
    logic [7:0]  data_left_reg, data_left_next;
    logic [7:0]  data_done_reg, data_done_next;
    logic [15:0] load_address_reg, load_address_next;
    logic [15:0] running_sum_reg, running_sum_next;
    logic [7:0]  check_high_reg, check_high_next;
    logic        halted_reg, halted_next;

    hrp_pkg::hex_t hex;
    logic [7:0]    byte_val;
    logic [15:0]   sum_add;
    logic          res_valid;

    hrp_hex_decode u_hex (
        .char_in (char_in),
        .hex     (hex)
    );

    assign byte_val = {nibble_high_reg, hex.value};
    assign sum_add  = running_sum_reg + {8'd0, byte_val};

    always_comb begin
        phase_next          = phase_reg;
        nibble_high_next    = nibble_high_reg;
        nibble_pending_next = nibble_pending_reg;
        field_idx_next      = field_idx_reg;
        data_left_next      = data_left_reg;
        data_done_next      = data_done_reg;
        load_address_next   = load_address_reg;
        running_sum_next    = running_sum_reg;
        check_high_next     = check_high_reg;
        halted_next         = halted_reg;
        res_valid           = 1'b0;
        res                 = '0;

        if (beat_accept && !halted_reg) begin
            unique case (phase_reg)
                hrp_pkg::PH_HUNT: begin
                    if (end_of_input) begin
                        halted_next = 1'b1;
                    end else if (char_in == hrp_pkg::CHAR_START) begin
                        phase_next          = hrp_pkg::PH_LEN;
                        running_sum_next    = '0;
                        nibble_pending_next = 1'b0;
                        field_idx_next      = 1'b0;
                    end
                end
                hrp_pkg::PH_LEN, hrp_pkg::PH_ADDR, hrp_pkg::PH_DATA,
                hrp_pkg::PH_CHECK: begin
                    if (end_of_input) begin
                        halted_next = 1'b1;
                        res_valid   = 1'b1;
                        res.kind    = hrp_pkg::KIND_EOF;
                    end else if (!hex.valid) begin
                        halted_next = 1'b1;
                        res_valid   = 1'b1;
                        res.kind    = hrp_pkg::KIND_BAD_HEX;
                    end else if (!nibble_pending_reg) begin
                        nibble_high_next    = hex.value;
                        nibble_pending_next = 1'b1;
                    end else begin
                        nibble_pending_next = 1'b0;
                        unique case (phase_reg)
                            hrp_pkg::PH_LEN: begin
                                running_sum_next = sum_add;
                                data_left_next   = byte_val;
                                data_done_next   = '0;
                                field_idx_next   = 1'b0;
                                phase_next       = hrp_pkg::PH_ADDR;
                            end
                            hrp_pkg::PH_ADDR: begin
                                running_sum_next = sum_add;
                                if (!field_idx_reg) begin
                                    load_address_next = {byte_val, 8'd0};
                                    field_idx_next    = 1'b1;
                                end else begin
                                    load_address_next = {load_address_reg[15:8], byte_val};
                                    field_idx_next    = 1'b0;
                                    if (data_left_reg == 8'd0) begin
                                        // end record: report and stop
                                        halted_next      = 1'b1;
                                        res_valid        = 1'b1;
                                        res.kind         = hrp_pkg::KIND_END;
                                        res.byte_address = {load_address_reg[15:8], byte_val};
                                    end else begin
                                        phase_next = hrp_pkg::PH_DATA;
                                    end
                                end
                            end
                            hrp_pkg::PH_DATA: begin
                                running_sum_next = sum_add;
                                data_done_next   = data_done_reg + 8'd1;
                                data_left_next   = data_left_reg - 8'd1;
                                if (data_left_reg == 8'd1) begin
                                    phase_next     = hrp_pkg::PH_CHECK;
                                    field_idx_next = 1'b0;
                                end
                                res_valid        = 1'b1;
                                res.kind         = hrp_pkg::KIND_DATA;
                                res.byte_address = load_address_reg + {8'd0, data_done_reg};
                                res.data_byte    = byte_val;
                            end
                            hrp_pkg::PH_CHECK: begin
                                if (!field_idx_reg) begin
                                    check_high_next = byte_val;
                                    field_idx_next  = 1'b1;
                                end else begin
                                    field_idx_next   = 1'b0;
                                    phase_next       = hrp_pkg::PH_HUNT;
                                    res_valid        = 1'b1;
                                    res.kind         =
                                        ({check_high_reg, byte_val} == running_sum_reg) ?
                                        hrp_pkg::KIND_OK : hrp_pkg::KIND_BAD_SUM;
                                    res.byte_address = load_address_reg;
                                    res.sum_computed = running_sum_reg;
                                end
                            end
                            default: phase_next = hrp_pkg::PH_HUNT;
                        endcase
                    end
                end
                default: phase_next = hrp_pkg::PH_HUNT;
            endcase
        end
    end

    assign status.res_valid = res_valid;
    assign status.halted    = halted_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg          <= hrp_pkg::PH_HUNT;
            nibble_pending_reg <= 1'b0;
            field_idx_reg      <= 1'b0;
            halted_reg         <= 1'b0;
        end else begin
            phase_reg          <= phase_next;
            nibble_pending_reg <= nibble_pending_next;
            field_idx_reg      <= field_idx_next;
            halted_reg         <= halted_next;
        end
    end

    always_ff @(posedge aclk) begin
        nibble_high_reg  <= nibble_high_next;
        data_left_reg    <= data_left_next;
        data_done_reg    <= data_done_next;
        load_address_reg <= load_address_next;
        running_sum_reg  <= running_sum_next;
        check_high_reg   <= check_high_next;
    end

endmodule

[hw/rtl/hex_record_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hex_record_parser
// Hex-text record parser: one character per beat in, data bytes and record
// status out, through an output register with a one-entry skid stage.
// ----------------------------------------------------------------------------
// Results reach m_* via the output register, or the skid entry when stalled.
// Throughput: one character per cycle while s_ready is high; state update is
// one pass of decode, byte assembly and a 16-bit add before the registers.
// s_ready drops only while the skid entry holds a result.
// Reset: synchronous, active low; returns to hunting for ';' and clears halt.
// ----------------------------------------------------------------------------
module hex_record_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_char_in,
    input  logic        s_end_of_input,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_kind,
    output logic [15:0] m_byte_address,
    output logic [7:0]  m_data_byte,
    output logic [15:0] m_sum_computed
);

    hrp_pkg::core_status_t core_status;
    hrp_pkg::result_t      core_res;
    hrp_pkg::result_t      out_reg, skid_reg;
    logic                  out_valid_reg, skid_valid_reg;
    logic                  beat_accept, push, pop;

    assign s_ready     = !skid_valid_reg;
    assign beat_accept = s_valid && s_ready;
    assign push        = beat_accept && core_status.res_valid;
    assign pop         = out_valid_reg && m_ready;

    hrp_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .beat_accept  (beat_accept),
        .char_in      (s_char_in),
        .end_of_input (s_end_of_input),
        .status       (core_status),
        .res          (core_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (pop) begin
            if (skid_valid_reg) begin
                out_reg        <= skid_reg;
                skid_valid_reg <= 1'b0;
            end else if (push) begin
                out_reg <= core_res;
            end else begin
                out_valid_reg <= 1'b0;
            end
        end else if (push) begin
            if (!out_valid_reg) begin
                out_reg       <= core_res;
                out_valid_reg <= 1'b1;
            end else begin
                // hold the new result while the output is stalled
                skid_reg       <= core_res;
                skid_valid_reg <= 1'b1;
            end
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_kind         = out_reg.kind;
    assign m_byte_address = out_reg.byte_address;
    assign m_data_byte    = out_reg.data_byte;
    assign m_sum_computed = out_reg.sum_computed;

    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds a result while the output register is empty");

    a_halt_sticks: assert property (@(posedge aclk) disable iff (!aresetn)
        core_status.halted |=> core_status.halted)
        else $error("halt cleared without reset");

    a_halt_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        core_status.halted |-> !core_status.res_valid)
        else $error("result produced while halted");

    a_kind_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_kind <= hrp_pkg::KIND_EOF))
        else $error("result kind out of range");

endmodule
